// File: src/lcch_pkg.sv
// Shared types, centroid constants and distance helper for the Lab cell histogram.
`default_nettype none

package lcch_pkg;

	// Number of stored centroids.
	localparam int TABLE_LEN = 15;
	// Width of a bin count; counts wrap at this width.
	localparam int CNT_W = 7;
	// Width of one color component in Q8.4.
	localparam int COMP_W = 12;
	// Width of a squared component difference.
	localparam int SQ_W = 2 * COMP_W;
	// Width of a full squared distance (sum of three squares).
	localparam int DIST_W = SQ_W + 2;

	// Centroids in unsigned Q8.4: L, a and b components.
	localparam logic [COMP_W-1:0] CENT_L [TABLE_LEN] = '{
		12'd2581, 12'd2287, 12'd1086, 12'd1483, 12'd1923,
		12'd3128, 12'd660,  12'd192,  12'd3625, 12'd2475,
		12'd1939, 12'd1393, 12'd1821, 12'd1297, 12'd720
	};
	localparam logic [COMP_W-1:0] CENT_A [TABLE_LEN] = '{
		12'd2036, 12'd2059, 12'd2044, 12'd2079, 12'd2052,
		12'd2046, 12'd2081, 12'd2072, 12'd2041, 12'd2107,
		12'd2192, 12'd2195, 12'd1705, 12'd2721, 12'd2217
	};
	localparam logic [COMP_W-1:0] CENT_B [TABLE_LEN] = '{
		12'd2058, 12'd2041, 12'd2174, 12'd2198, 12'd2033,
		12'd2070, 12'd2123, 12'd2033, 12'd2182, 12'd2504,
		12'd2455, 12'd1578, 12'd2525, 12'd2382, 12'd1638
	};

	// Handshake tag that travels with a pixel down the pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} pix_tag_t;

	// Square of the absolute difference of two Q8.4 components.
	function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] p,
		input logic [COMP_W-1:0] c);
		logic [COMP_W-1:0] d;
		d = (p >= c) ? (p - c) : (c - p);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

endpackage

`default_nettype wire

// File: src/lcch_nearest.sv
// Pipelined nearest-centroid search: distances, group minimum, final minimum.
`default_nettype none

module lcch_nearest import lcch_pkg::*; #(
	parameter int NUM_BINS = 15
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pix_tag_t                    tag_in,
	input  wire logic [7:0]                  lab_l,
	input  wire logic [7:0]                  lab_a,
	input  wire logic [7:0]                  lab_b,
	output pix_tag_t                         tag_out,
	output logic [$clog2(NUM_BINS)-1:0]      idx_out
);

	localparam int IW = $clog2(NUM_BINS);
	localparam int NG = (NUM_BINS + 3) / 4;

	pix_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [COMP_W-1:0] l_s1, a_s1, b_s1;
	logic [DIST_W-1:0] dist_s2 [NUM_BINS];
	logic [DIST_W-1:0] gdist_s3 [NG];
	logic [IW-1:0]     gidx_s3 [NG];
	logic [IW-1:0]     idx_s4;

	logic [DIST_W-1:0] dist_c  [NUM_BINS];
	logic [DIST_W-1:0] gdist_c [NG];
	logic [IW-1:0]     gidx_c  [NG];
	logic [DIST_W-1:0] fdist_c;
	logic [IW-1:0]     fidx_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Pixel components are scaled into Q8.4 as they are registered.
	always_ff @(posedge clk) begin
		if (tag_in.valid) begin
			l_s1 <= {lab_l, 4'b0000};
			a_s1 <= {lab_a, 4'b0000};
			b_s1 <= {lab_b, 4'b0000};
		end
		dist_s2 <= dist_c;
		gdist_s3 <= gdist_c;
		gidx_s3 <= gidx_c;
		idx_s4 <= fidx_c;
	end

	always_comb begin
		for (int k = 0; k < NUM_BINS; k++) begin
			dist_c[k] = DIST_W'(sq_diff(l_s1, CENT_L[k])) + DIST_W'(sq_diff(a_s1, CENT_A[k]))
				+ DIST_W'(sq_diff(b_s1, CENT_B[k]));
		end
	end

	// Scanning upward with a strict compare keeps the lowest index on a tie.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			gdist_c[g] = dist_s2[g * 4];
			gidx_c[g] = IW'(g * 4);
			for (int j = 1; j < 4; j++) begin
				if (g * 4 + j < NUM_BINS) begin
					if (dist_s2[g * 4 + j] < gdist_c[g]) begin
						gdist_c[g] = dist_s2[g * 4 + j];
						gidx_c[g] = IW'(g * 4 + j);
					end
				end
			end
		end
	end

	always_comb begin
		fdist_c = gdist_s3[0];
		fidx_c = gidx_s3[0];
		for (int g = 1; g < NG; g++) begin
			if (gdist_s3[g] < fdist_c) begin
				fdist_c = gdist_s3[g];
				fidx_c = gidx_s3[g];
			end
		end
	end

	assign tag_out = tag_s4;
	assign idx_out = idx_s4;

endmodule

`default_nettype wire

// File: src/lab_centroid_cell_histogram_top.sv
// Top level of the Lab nearest-centroid cell histogram.
//
//   channel | direction | payload                          | accepted when
//   in      | input     | lab_l, lab_a, lab_b              | in_valid & in_ready
//   out     | output    | bin_index, bin_count, last_bin   | out_valid & out_ready
//   cfg     | input     | cell_side                        | cfg_valid & cfg_ready
//
// Pixels are taken one per clock while a cell is open. A pixel passes through the
// nearest-centroid pipeline and then the histogram read-modify-write; back-to-back
// hits on the same bin are forwarded from the last write.
// The pixel that closes a cell blocks the input until its histogram has been read out:
// the pipeline drains, then each bin takes a memory read and then an output load,
// and the load waits while out_ready is held low. The output register lets a word wait.
// Reset clears the bin valid bits, so the histogram reads as all zero without a sweep,
// and sets cell_side to 4. The configuration port is always ready.
`default_nettype none

module lab_centroid_cell_histogram_top import lcch_pkg::*; #(
	parameter int NUM_CENTROIDS = 15,
	parameter int MAX_CELL_SIDE = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] lab_l,
	input  wire logic [7:0] lab_a,
	input  wire logic [7:0] lab_b,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      bin_index,
	output logic [6:0]      bin_count,
	output logic            last_bin,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cell_side
);

	// Only the stored centroids take part, however many are asked for.
	localparam int NB = (NUM_CENTROIDS < TABLE_LEN) ? NUM_CENTROIDS : TABLE_LEN;
	localparam int IW = $clog2(NB);
	localparam int PW = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE + 1);

	// Sequencer states.
	localparam logic [1:0] ST_PIX = 2'd0;  // taking pixels
	localparam logic [1:0] ST_RD  = 2'd1;  // reading one bin for readout
	localparam logic [1:0] ST_WT  = 2'd2;  // waiting to load the output register

	// Configuration register.
	logic [3:0] cell_side_q;

	// Effective side and cell size. A zero side acts as one, and anything above the
	// maximum is clamped to it.
	logic [4:0] side_eff;
	logic [9:0] cell_pix;

	// Input side.
	logic          in_acc;
	logic          closing;
	logic [PW-1:0] pix_q;
	logic          hold_q;

	// Pixel pipeline.
	pix_tag_t      tag_in, tag_s4, tag_s5;
	logic [IW-1:0] idx_s4, idx_s5;

	// Histogram memory with its valid bits and read port.
	logic [CNT_W-1:0] hist_mem [NB];
	logic [NB-1:0]    bin_vld_q;
	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic [CNT_W-1:0] rd_data_q;
	logic             rd_vld_q;

	// Last write, for forwarding to a pixel right behind on the same bin.
	logic             lw_en_q;
	logic [IW-1:0]    lw_addr_q;
	logic [CNT_W-1:0] lw_data_q;
	logic [CNT_W-1:0] cnt_cur;
	logic [CNT_W-1:0] cnt_new;

	// Readout sequencer and output register.
	logic [1:0]       state_q;
	logic [IW-1:0]    bin_q;
	logic             out_free;
	logic             out_load;
	logic             out_valid_q;
	logic [IW-1:0]    out_idx_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_last_q;

	always_comb begin
		if (cell_side_q == 4'd0) begin
			side_eff = 5'd1;
		end else if ({1'b0, cell_side_q} > 5'(MAX_CELL_SIDE)) begin
			side_eff = 5'(MAX_CELL_SIDE);
		end else begin
			side_eff = {1'b0, cell_side_q};
		end
	end

	assign cell_pix = 10'(side_eff) * 10'(side_eff);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_side_q <= 4'd4;
		end else if (cfg_valid && cfg_ready) begin
			cell_side_q <= cell_side;
		end
	end

	// The pixel counter runs at the input. The pixel that fills the cell is tagged and
	// the input then stays closed until the readout has finished.
	assign in_ready = !hold_q;
	assign in_acc = in_valid && in_ready;
	assign closing = (10'(pix_q) + 10'd1) >= cell_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (in_acc) begin
			pix_q <= closing ? '0 : PW'(pix_q + 1'b1);
		end
	end

	assign tag_in = '{valid: in_acc, last: in_acc && closing};

	lcch_nearest #(
		.NUM_BINS(NB)
	) u_nearest (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (tag_in),
		.lab_l   (lab_l),
		.lab_a   (lab_a),
		.lab_b   (lab_b),
		.tag_out (tag_s4),
		.idx_out (idx_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
		end else begin
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s5 <= idx_s4;
	end

	// The read port serves the readout when it runs and the pixel pipeline otherwise;
	// the two never overlap because the input is closed during readout.
	assign rd_en = (state_q == ST_RD) || tag_s4.valid;
	assign rd_addr = (state_q == ST_RD) ? bin_q : idx_s4;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= hist_mem[rd_addr];
			rd_vld_q <= bin_vld_q[rd_addr];
		end
		if (tag_s5.valid) begin
			hist_mem[idx_s5] <= cnt_new;
		end
	end

	// A read issued in the same cycle as a write to the same bin sees the old count,
	// so the count just written is taken instead.
	always_comb begin
		if (lw_en_q && (lw_addr_q == idx_s5)) begin
			cnt_cur = lw_data_q;
		end else if (rd_vld_q) begin
			cnt_cur = rd_data_q;
		end else begin
			cnt_cur = '0;
		end
	end

	assign cnt_new = CNT_W'(cnt_cur + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_en_q <= 1'b0;
		end else begin
			lw_en_q <= tag_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s5.valid) begin
			lw_addr_q <= idx_s5;
			lw_data_q <= cnt_new;
		end
	end

	// Valid bits: set by a pixel write, cleared as each bin is read out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
		end else begin
			if (tag_s5.valid) begin
				bin_vld_q[idx_s5] <= 1'b1;
			end
			if (state_q == ST_RD) begin
				bin_vld_q[bin_q] <= 1'b0;
			end
		end
	end

	// Readout sequencer: one read, then one output load, for each bin in turn.
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == ST_WT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PIX;
			bin_q <= '0;
			hold_q <= 1'b0;
		end else begin
			if (in_acc && closing) begin
				hold_q <= 1'b1;
			end
			case (state_q)
				ST_PIX: begin
					if (tag_s5.valid && tag_s5.last) begin
						state_q <= ST_RD;
						bin_q <= '0;
					end
				end
				ST_RD: begin
					state_q <= ST_WT;
				end
				ST_WT: begin
					if (out_free) begin
						if (bin_q == IW'(NB - 1)) begin
							state_q <= ST_PIX;
							hold_q <= 1'b0;
						end else begin
							state_q <= ST_RD;
							bin_q <= IW'(bin_q + 1'b1);
						end
					end
				end
				default: begin
					state_q <= ST_PIX;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q <= bin_q;
			out_cnt_q <= rd_vld_q ? rd_data_q : '0;
			out_last_q <= (bin_q == IW'(NB - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = 4'(out_idx_q);
	assign bin_count = out_cnt_q;
	assign last_bin = out_last_q;

	// The readout and the pixel pipeline must never share the read port.
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!((state_q == ST_RD) && tag_s4.valid))
		else $error("readout read collides with a pixel read");

	// No pixel enters while a cell is being read out.
	a_no_pix_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_PIX) |-> !in_ready)
		else $error("input open during readout");

	// The last word of a cell always carries the highest bin number.
	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_bin) |-> (bin_index == 4'(NB - 1)))
		else $error("last_bin on a bin other than the final one");

	// Readout begins only right after the closing pixel has updated its bin.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_RD) && (bin_q == '0) |-> $past(tag_s5.valid && tag_s5.last))
		else $error("readout started without a closing pixel");

endmodule

`default_nettype wire
